// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pct_pkg.sv -----
// ---------------------------------------------------------------------------
// Packet coalescing table package
// Types and codes shared by the table core and its checker.
// ---------------------------------------------------------------------------
package pct_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] off;
  } entry_t;

  localparam logic       MODE_OFFER = 1'b0;
  localparam logic       MODE_SEND  = 1'b1;

  localparam logic [2:0] ACT_APPEND   = 3'd0;
  localparam logic [2:0] ACT_REPLACE  = 3'd1;
  localparam logic [2:0] ACT_MISMATCH = 3'd2;
  localparam logic [2:0] ACT_FULL     = 3'd3;
  localparam logic [2:0] ACT_SENT     = 3'd4;

  localparam logic       REG_MAX_FRAME = 1'b0;
  localparam logic [7:0] MAX_FRAME_RESET = 8'd252;

endpackage

// ----- hdl/packet_coalescing_table_core.sv -----
// ---------------------------------------------------------------------------
// Packet coalescing table core
// An item is taken in only while the block is idle. The scan then reads the
// stored entries in turn, and the result moves to the output register before
// the next item can be taken in. A hit or a frame that fills up early ends
// the scan at that entry, one read a cycle from the entry memory. A stalled
// result holds the block in its last step.
// Reset empties the table, restores max_frame_length and clears out_valid.
// ---------------------------------------------------------------------------
module packet_coalescing_table_core
  import pct_pkg::*;
#(
  parameter int MAX_ENTRIES   = 8,
  parameter int TRAILER_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  msg_id,
  input  logic [7:0]  msg_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  buffer_offset,
  output logic [7:0]  frame_length,
  output logic [7:0]  entries_sent
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
  localparam logic [7:0]       TRAILER8 = 8'(TRAILER_BYTES);

  state_t state, state_next;

  logic [7:0]       max_frame_length;
  logic             op_mode;
  logic [7:0]       op_id;
  logic [7:0]       op_len;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [7:0]       end_off, end_off_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend, pend_next;
  logic             pend_first, pend_first_next;
  logic [7:0]       size, size_next;
  logic [CNT_W-1:0] taken, taken_next;
  logic [2:0]       res_action, res_action_next;
  logic [7:0]       res_offset, res_offset_next;
  logic [7:0]       res_flen, res_flen_next;
  logic [CNT_W-1:0] res_cnt, res_cnt_next;
  logic             load_out;

  entry_t           mem [MAX_ENTRIES];
  entry_t           rd_data;
  entry_t           mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  logic [8:0]       sum9;
  logic             stop;
  logic [7:0]       append_off;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_FRAME) ? {24'd0, max_frame_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FRAME) begin
      max_frame_length <= pwdata[7:0];
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx[IDX_W-1:0]];
  end

  assign in_ready   = (state == ST_IDLE);
  assign sum9       = {1'b0, size} + {1'b0, rd_data.len};
  assign append_off = (entry_count == '0) ? 8'd0 : end_off;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    end_off_next     = end_off;
    idx_next         = idx;
    pend_next        = pend;
    pend_first_next  = pend_first;
    size_next        = size;
    taken_next       = taken;
    res_action_next  = res_action;
    res_offset_next  = res_offset;
    res_flen_next    = res_flen;
    res_cnt_next     = res_cnt;
    load_out         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = entry_count[IDX_W-1:0];
    mem_wdata        = '{id: op_id, len: op_len, off: append_off};
    stop             = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
          idx_next   = '0;
          pend_next  = 1'b0;
          size_next  = TRAILER8;
          taken_next = '0;
        end
      end

      ST_SCAN: begin
        // The read issued now returns next cycle; the one issued last cycle is checked now.
        if (idx != entry_count) begin
          idx_next        = idx + 1'b1;
          pend_next       = 1'b1;
          pend_first_next = (idx == '0);
        end else begin
          pend_next = 1'b0;
        end

        if (op_mode == MODE_SEND) begin
          if (pend) begin
            if (pend_first) begin
              size_next  = rd_data.len + TRAILER8;
              taken_next = CNT_W'(1);
            end else if (sum9 > {1'b0, max_frame_length}) begin
              stop = 1'b1;
            end else begin
              size_next  = sum9[7:0];
              taken_next = taken + 1'b1;
            end
          end
          if (stop || idx == entry_count) begin
            res_action_next  = ACT_SENT;
            res_offset_next  = 8'd0;
            res_flen_next    = size_next;
            res_cnt_next     = taken_next;
            entry_count_next = '0;
            state_next       = ST_DONE;
          end
        end else begin
          if (pend && rd_data.id == op_id) begin
            res_flen_next = 8'd0;
            res_cnt_next  = '0;
            if (rd_data.len == op_len) begin
              res_action_next = ACT_REPLACE;
              res_offset_next = rd_data.off;
            end else begin
              res_action_next = ACT_MISMATCH;
              res_offset_next = 8'd0;
            end
            state_next = ST_DONE;
          end else if (idx == entry_count) begin
            res_flen_next = 8'd0;
            res_cnt_next  = '0;
            if (entry_count < CNT_MAX) begin
              mem_we           = 1'b1;
              entry_count_next = entry_count + 1'b1;
              end_off_next     = append_off + op_len;
              res_action_next  = ACT_APPEND;
              res_offset_next  = append_off;
            end else begin
              res_action_next = ACT_FULL;
              res_offset_next = 8'd0;
            end
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      pend        <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    end_off    <= end_off_next;
    idx        <= idx_next;
    pend_first <= pend_first_next;
    size       <= size_next;
    taken      <= taken_next;
    res_action <= res_action_next;
    res_offset <= res_offset_next;
    res_flen   <= res_flen_next;
    res_cnt    <= res_cnt_next;
    if (in_valid && in_ready) begin
      op_mode <= mode;
      op_id   <= msg_id;
      op_len  <= msg_length;
    end
  end

  // Output register: a finished item waits here while the next one is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      action        <= res_action;
      buffer_offset <= res_offset;
      frame_length  <= res_flen;
      entries_sent  <= 8'(res_cnt);
    end
  end

endmodule

// ----- hdl/pct_checker.sv -----
// ---------------------------------------------------------------------------
// Packet coalescing table checker
// Watches the result channel of the table core from its ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pct_checker
  import pct_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] action,
  input logic [7:0] buffer_offset,
  input logic [7:0] frame_length,
  input logic [7:0] entries_sent
);

  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(action) && $stable(buffer_offset), "stalled result changed")
  `ASSERT_RST(a_action_code, clk, rst, out_valid |-> action <= ACT_SENT, "result carries an unknown action")
  `ASSERT_RST(a_offer_fields, clk, rst, out_valid && action != ACT_SENT |-> frame_length == 8'd0 && entries_sent == 8'd0, "offer result carries frame fields")
  `ASSERT_RST(a_drop_offset, clk, rst, out_valid && (action == ACT_SENT || action == ACT_MISMATCH || action == ACT_FULL) |-> buffer_offset == 8'd0, "offset given without a write")
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind packet_coalescing_table_core pct_checker u_pct_checker (.*);
